// ===== rtl/smbh_pkg.sv =====
// Shared types and constants for the sweep-map best-heading block.
// Used by the modules under rtl except smbh_map; has no dependencies of its own.
package smbh_pkg;

  localparam int unsigned SLOT_W     = 5;
  localparam int unsigned DIST_W     = 14;
  localparam int unsigned DEG_W      = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 14;

  localparam int unsigned DIST_LIMIT = 10000;

  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CLEAR  = 2'd2;

  localparam logic [SLOT_W-1:0] SWEEP_LOW_RST  = 5'd0;
  localparam logic [SLOT_W-1:0] SWEEP_HIGH_RST = 5'd18;
  localparam logic [DIST_W-1:0] MIN_CLEAR_RST  = 14'd100;

  localparam logic [DEG_W-1:0] DEG_PER_SLOT  = 8'd10;
  localparam logic [DEG_W-1:0] DEG_HALF_SLOT = 8'd5;

  typedef struct packed {
    logic              valid;
    logic [DEG_W-1:0]  heading;
    logic [DEG_W-1:0]  open_lo;
    logic [DEG_W-1:0]  open_hi;
    logic [DIST_W-1:0] best;
  } res_t;

  typedef struct packed {
    logic gt;
    logic eq;
  } cmp_t;

endpackage

// ===== rtl/smbh_map.sv =====
// Range map storage: one write port, one registered read port.
// Per-entry valid bits make every entry read as zero after reset.
module smbh_map #(
  parameter int unsigned NUM_SLOTS = 19,
  parameter int unsigned DIST_BITS = 14,
  localparam int unsigned AW = $clog2(NUM_SLOTS)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_en_i,
  input  logic [AW-1:0]        wr_addr_i,
  input  logic [DIST_BITS-1:0] wr_data_i,
  input  logic [AW-1:0]        rd_addr_i,
  output logic [DIST_BITS-1:0] rd_data_o
);

  logic [DIST_BITS-1:0] mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] vld_q;
  logic [DIST_BITS-1:0] rd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // an entry never written reads as zero
  always_ff @(posedge clk_i) begin
    rd_data_q <= vld_q[rd_addr_i] ? mem[rd_addr_i] : '0;
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/smbh_cmp.sv =====
// Shared magnitude comparator used for every map test of the sequencer.
// Depends on smbh_pkg for the result struct.
module smbh_cmp import smbh_pkg::*; #(
  parameter int unsigned W = 14
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  output cmp_t         res_o
);

  assign res_o.gt = (a_i > b_i);
  assign res_o.eq = (a_i == b_i);

endmodule

// ===== rtl/smbh_seq.sv =====
// Sequencer: front check, maximum scan and plateau walk over the range map.
// Depends on smbh_pkg and instantiates smbh_cmp.
module smbh_seq import smbh_pkg::*; #(
  parameter int unsigned NUM_SLOTS  = 19,
  parameter int unsigned DIST_BITS  = 14,
  parameter int unsigned FRONT_SLOT = 9,
  localparam int unsigned AW = $clog2(NUM_SLOTS)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DIST_W-1:0]    clear_i,
  input  logic [SLOT_W-1:0]    sweep_low_i,
  input  logic [SLOT_W-1:0]    sweep_high_i,
  input  logic                 out_free_i,
  input  logic [DIST_BITS-1:0] rd_data_i,
  output logic [AW-1:0]        rd_addr_o,
  output logic                 busy_o,
  output logic                 res_load_o,
  output res_t                 res_o
);

  localparam int unsigned CW    = ((AW > SLOT_W) ? AW : SLOT_W) + 1;
  localparam int unsigned CMP_W = (DIST_BITS > DIST_W) ? DIST_BITS : DIST_W;
  localparam bit          FRONT_OK = (FRONT_SLOT < NUM_SLOTS);
  localparam logic [AW-1:0] FRONT_ADDR = AW'(FRONT_SLOT);
  localparam logic [CW-1:0] LAST_SLOT  = CW'(NUM_SLOTS - 1);

  typedef enum logic [9:0] {
    ST_IDLE     = 10'b00_0000_0001,
    ST_FRONT_RD = 10'b00_0000_0010,
    ST_FRONT_CK = 10'b00_0000_0100,
    ST_SCAN_RD  = 10'b00_0000_1000,
    ST_SCAN_CK  = 10'b00_0001_0000,
    ST_LO_RD    = 10'b00_0010_0000,
    ST_LO_CK    = 10'b00_0100_0000,
    ST_HI_RD    = 10'b00_1000_0000,
    ST_HI_CK    = 10'b01_0000_0000,
    ST_DONE     = 10'b10_0000_0000
  } state_e;

  state_e               state_q, state_d;
  logic [CW-1:0]        scan_q, scan_d;
  logic [DIST_BITS-1:0] best_dist_q, best_dist_d;
  logic                 found_q, found_d;
  logic                 hv_q, hv_d;
  logic [AW-1:0]        lo_q, lo_d;
  logic [AW-1:0]        hi_q, hi_d;

  logic [CW-1:0]        hi_lim;
  logic [CMP_W-1:0]     cmp_ref;
  logic [CMP_W-1:0]     best_ext;
  cmp_t                 cmp;
  logic [DEG_W-1:0]     lo_deg, hi_deg, span;

  assign hi_lim = (CW'(sweep_high_i) > LAST_SLOT) ? LAST_SLOT : CW'(sweep_high_i);

  // the clearance is the bar until a free slot is found; from then on the best
  // distance is above it, so one compare covers both the scan and the walk
  assign cmp_ref = found_q ? CMP_W'(best_dist_q) : CMP_W'(clear_i);

  smbh_cmp #(.W(CMP_W)) u_cmp (
    .a_i   (CMP_W'(rd_data_i)),
    .b_i   (cmp_ref),
    .res_o (cmp)
  );

  always_comb begin
    state_d     = state_q;
    scan_d      = scan_q;
    best_dist_d = best_dist_q;
    found_d     = found_q;
    hv_d        = hv_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    rd_addr_o   = '0;
    res_load_o  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          found_d = 1'b0;
          hv_d    = 1'b0;
          state_d = ST_FRONT_RD;
        end
      end
      ST_FRONT_RD: begin
        if (FRONT_OK) begin
          rd_addr_o = FRONT_ADDR;
          state_d   = ST_FRONT_CK;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_FRONT_CK: begin
        if (cmp.gt) begin
          scan_d      = CW'(sweep_low_i);
          best_dist_d = '0;
          state_d     = ST_SCAN_RD;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_SCAN_RD: begin
        if (scan_q > hi_lim) begin
          hv_d    = found_q;
          state_d = found_q ? ST_LO_RD : ST_DONE;
        end else begin
          rd_addr_o = scan_q[AW-1:0];
          state_d   = ST_SCAN_CK;
        end
      end
      ST_SCAN_CK: begin
        // strictly greater keeps the first slot of equal maxima
        if (cmp.gt) begin
          best_dist_d = rd_data_i;
          found_d     = 1'b1;
          lo_d        = scan_q[AW-1:0];
          hi_d        = scan_q[AW-1:0];
        end
        scan_d  = scan_q + CW'(1);
        state_d = ST_SCAN_RD;
      end
      ST_LO_RD: begin
        // lower edge may not reach slot zero
        if (lo_q >= AW'(2)) begin
          rd_addr_o = lo_q - AW'(1);
          state_d   = ST_LO_CK;
        end else begin
          state_d = ST_HI_RD;
        end
      end
      ST_LO_CK: begin
        if (cmp.eq) begin
          lo_d    = lo_q - AW'(1);
          state_d = ST_LO_RD;
        end else begin
          state_d = ST_HI_RD;
        end
      end
      ST_HI_RD: begin
        if (CW'(hi_q) < LAST_SLOT) begin
          rd_addr_o = hi_q + AW'(1);
          state_d   = ST_HI_CK;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_HI_CK: begin
        if (cmp.eq) begin
          hi_d    = hi_q + AW'(1);
          state_d = ST_HI_RD;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the output register can take the beat
        if (out_free_i) begin
          res_load_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      found_q <= 1'b0;
      hv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      found_q <= found_d;
      hv_q    <= hv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q      <= scan_d;
    best_dist_q <= best_dist_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
  end

  // degrees wrap at 8 bits; half of ten times the span is five times the span
  assign lo_deg   = DEG_W'(lo_q) * DEG_PER_SLOT;
  assign hi_deg   = DEG_W'(hi_q) * DEG_PER_SLOT;
  assign span     = DEG_W'(hi_q) - DEG_W'(lo_q);
  assign best_ext = CMP_W'(best_dist_q);

  always_comb begin
    res_o = '0;
    if (hv_q) begin
      res_o.valid   = 1'b1;
      res_o.heading = lo_deg + span * DEG_HALF_SLOT;
      res_o.open_lo = lo_deg;
      res_o.open_hi = hi_deg;
      res_o.best    = best_ext[DIST_W-1:0];
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

// ===== rtl/sweep_map_best_heading_unit.sv =====
// Sweep-map best-heading unit: range map store, heading sequencer, output register.
// Depends on smbh_pkg; instantiates smbh_map and smbh_seq.
//
// Each input beat stores one saturated distance (cap 10000) into its slot of
// the range map, unless the slot lies outside the map, and then searches the
// map for the best free heading; one result beat follows every input beat. The
// map is cleared at reset through per-slot valid bits, so the block is ready
// right after reset. One shared comparator walks the map under a sequencer,
// with a read state and a check state for each map read. in_stall_o is high
// while a search runs and while a finished result waits for a stalled output
// register. A finished result sits in the output register so the next beat
// is taken while it waits.
module sweep_map_best_heading_unit import smbh_pkg::*; #(
  parameter int unsigned NUM_SLOTS  = 19,
  parameter int unsigned DIST_BITS  = 14,
  parameter int unsigned FRONT_SLOT = 9
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [SLOT_W-1:0]     slot_i,
  input  logic [DIST_W-1:0]     distance_mm_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  heading_valid_o,
  output logic [DEG_W-1:0]      heading_deg_o,
  output logic [DEG_W-1:0]      opening_low_deg_o,
  output logic [DEG_W-1:0]      opening_high_deg_o,
  output logic [DIST_W-1:0]     best_distance_mm_o
);

  localparam int unsigned AW    = $clog2(NUM_SLOTS);
  localparam int unsigned CW    = ((AW > SLOT_W) ? AW : SLOT_W) + 1;
  localparam int unsigned CMP_W = (DIST_BITS > DIST_W) ? DIST_BITS : DIST_W;
  localparam int unsigned DIST_MAX = (1 << DIST_BITS) - 1;
  localparam int unsigned DIST_CAP = (DIST_LIMIT < DIST_MAX) ? DIST_LIMIT : DIST_MAX;

  logic [SLOT_W-1:0] sweep_low_q, sweep_low_d;
  logic [SLOT_W-1:0] sweep_high_q, sweep_high_d;
  logic [DIST_W-1:0] clear_q, clear_d;

  logic                 busy;
  logic                 in_accept;
  logic                 wr_en;
  logic [CMP_W-1:0]     dist_ext;
  logic [CMP_W-1:0]     dist_sat;
  logic [AW-1:0]        rd_addr;
  logic [DIST_BITS-1:0] rd_data;
  logic                 res_load;
  res_t                 res;
  logic                 out_free;

  logic out_valid_q, out_valid_d;
  res_t res_q;

  always_comb begin
    sweep_low_d  = sweep_low_q;
    sweep_high_d = sweep_high_q;
    clear_d      = clear_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SWEEP_LOW:  sweep_low_d  = cfg_wdata_i[SLOT_W-1:0];
        REG_SWEEP_HIGH: sweep_high_d = cfg_wdata_i[SLOT_W-1:0];
        REG_MIN_CLEAR:  clear_d      = cfg_wdata_i[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_low_q  <= SWEEP_LOW_RST;
      sweep_high_q <= SWEEP_HIGH_RST;
      clear_q      <= MIN_CLEAR_RST;
    end else begin
      sweep_low_q  <= sweep_low_d;
      sweep_high_q <= sweep_high_d;
      clear_q      <= clear_d;
    end
  end

  assign in_stall_o = busy;
  assign in_accept  = in_valid_i && !busy;

  // drop the store for a slot outside the map; the search still runs
  assign wr_en    = in_accept && (CW'(slot_i) < CW'(NUM_SLOTS));
  assign dist_ext = CMP_W'(distance_mm_i);
  assign dist_sat = (dist_ext > CMP_W'(DIST_CAP)) ? CMP_W'(DIST_CAP) : dist_ext;

  smbh_map #(
    .NUM_SLOTS (NUM_SLOTS),
    .DIST_BITS (DIST_BITS)
  ) u_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (AW'(slot_i)),
    .wr_data_i (dist_sat[DIST_BITS-1:0]),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  smbh_seq #(
    .NUM_SLOTS  (NUM_SLOTS),
    .DIST_BITS  (DIST_BITS),
    .FRONT_SLOT (FRONT_SLOT)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (in_accept),
    .clear_i      (clear_q),
    .sweep_low_i  (sweep_low_q),
    .sweep_high_i (sweep_high_q),
    .out_free_i   (out_free),
    .rd_data_i    (rd_data),
    .rd_addr_o    (rd_addr),
    .busy_o       (busy),
    .res_load_o   (res_load),
    .res_o        (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= res;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign heading_valid_o    = res_q.valid;
  assign heading_deg_o      = res_q.heading;
  assign opening_low_deg_o  = res_q.open_lo;
  assign opening_high_deg_o = res_q.open_hi;
  assign best_distance_mm_o = res_q.best;

endmodule

// ===== dv/tb_sweep_map_best_heading_unit.sv =====
// Self-checking testbench for sweep_map_best_heading_unit: directed and random range readings,
// register settings and back-pressure, checked against an in-bench heading predictor.
// Depends on smbh_pkg and the RTL under rtl; needs nothing else.
`timescale 1ns / 1ps

module tb_sweep_map_best_heading_unit;
  import smbh_pkg::*;

  localparam int unsigned NUM_SLOTS   = 19;
  localparam int unsigned DIST_BITS   = 14;
  localparam int unsigned FRONT_SLOT  = 9;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned DRAIN_WAIT  = 200;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
  localparam logic [DIST_W-1:0]    DIST_TOP     = '1;

  logic                  clk_i              = 1'b0;
  logic                  rst_ni             = 1'b0;
  logic                  cfg_we_i           = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i          = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i        = '0;
  logic                  in_valid_i         = 1'b0;
  logic                  in_stall_o;
  logic [SLOT_W-1:0]     slot_i             = '0;
  logic [DIST_W-1:0]     distance_mm_i      = '0;
  logic                  out_valid_o;
  logic                  out_stall_i        = 1'b0;
  logic                  heading_valid_o;
  logic [DEG_W-1:0]      heading_deg_o;
  logic [DEG_W-1:0]      opening_low_deg_o;
  logic [DEG_W-1:0]      opening_high_deg_o;
  logic [DIST_W-1:0]     best_distance_mm_o;

  // Predictor state: own copy of the range map and of the registers.
  logic [DIST_W-1:0] map_mm [NUM_SLOTS] = '{default: '0};
  logic [SLOT_W-1:0] sweep_lo_r = SWEEP_LOW_RST;
  logic [SLOT_W-1:0] sweep_hi_r = SWEEP_HIGH_RST;
  logic [DIST_W-1:0] clear_r    = MIN_CLEAR_RST;

  res_t heading_q [$];

  logic [DIST_W-1:0] palette [4];
  int unsigned       palette_n = 1;

  int unsigned send_idle_pct    = 0;
  int unsigned recv_stall_pct   = 0;
  int unsigned cycle_count      = 0;
  int unsigned readings_sent    = 0;
  int unsigned headings_checked = 0;
  int unsigned settings_applied = 0;
  int unsigned mismatch_count   = 0;

  logic        hold_toggle = 1'b0;
  logic        hold_seen   = 1'b0;
  int unsigned hold_left   = 0;

  sweep_map_best_heading_unit #(
    .NUM_SLOTS  (NUM_SLOTS),
    .DIST_BITS  (DIST_BITS),
    .FRONT_SLOT (FRONT_SLOT)
  ) i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .slot_i             (slot_i),
    .distance_mm_i      (distance_mm_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .heading_valid_o    (heading_valid_o),
    .heading_deg_o      (heading_deg_o),
    .opening_low_deg_o  (opening_low_deg_o),
    .opening_high_deg_o (opening_high_deg_o),
    .best_distance_mm_o (best_distance_mm_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d headings still due", cycle_count, heading_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: random stall, or a long hold-off when one is requested.
  always @(posedge clk_i) begin
    if (hold_toggle != hold_seen) begin
      hold_seen   <= hold_toggle;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99, 0) < recv_stall_pct);
    end
  end

  // Check every result beat against the oldest predicted heading.
  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {heading_valid_o, heading_deg_o, opening_low_deg_o, opening_high_deg_o,
             best_distance_mm_o};
      if (heading_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("Unexpected result beat at cycle %0d: valid=%0d heading=%0d", cycle_count,
                   got.valid, got.heading);
      end else begin
        want = heading_q.pop_front();
        headings_checked++;
        if (got.valid !== want.valid || got.heading !== want.heading ||
            got.open_lo !== want.open_lo || got.open_hi !== want.open_hi ||
            got.best !== want.best) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("Mismatch at cycle %0d: exp v=%0d hd=%0d lo=%0d hi=%0d d=%0d, got v=%0d hd=%0d lo=%0d hi=%0d d=%0d",
                     cycle_count, want.valid, want.heading, want.open_lo, want.open_hi,
                     want.best, got.valid, got.heading, got.open_lo, got.open_hi, got.best);
        end
      end
    end
  end

  function automatic res_t predict_heading();
    res_t        r;
    int unsigned top;
    int unsigned s;
    int unsigned best_slot;
    int unsigned lo_e;
    int unsigned hi_e;
    logic [DIST_W-1:0] best_d;
    bit          found;
    r         = '0;
    best_d    = '0;
    best_slot = 0;
    found     = 1'b0;
    if (!(map_mm[FRONT_SLOT] > clear_r)) return r;
    top = (sweep_hi_r > NUM_SLOTS - 1) ? NUM_SLOTS - 1 : sweep_hi_r;
    for (s = sweep_lo_r; s <= top; s++) begin
      if (map_mm[s] > best_d && map_mm[s] > clear_r) begin
        best_slot = s;
        best_d    = map_mm[s];
        found     = 1'b1;
      end
    end
    if (!found) return r;
    // Widen over equal neighbors; slot 0 never joins the low side.
    lo_e = best_slot;
    hi_e = best_slot;
    while (lo_e > 1 && map_mm[lo_e - 1] == best_d) lo_e--;
    while (hi_e + 1 < NUM_SLOTS && map_mm[hi_e + 1] == best_d) hi_e++;
    r.valid   = 1'b1;
    r.open_lo = DEG_W'(lo_e * DEG_PER_SLOT);
    r.open_hi = DEG_W'(hi_e * DEG_PER_SLOT);
    r.heading = DEG_W'(lo_e * DEG_PER_SLOT + ((hi_e - lo_e) * DEG_PER_SLOT) / 2);
    r.best    = best_d;
    return r;
  endfunction

  function automatic logic [SLOT_W-1:0] pick_slot();
    if ($urandom_range(9, 0) == 0) return SLOT_W'($urandom_range(31, NUM_SLOTS));
    return SLOT_W'($urandom_range(NUM_SLOTS - 1, 0));
  endfunction

  // Mostly palette values so that ties and plateaus are common.
  function automatic logic [DIST_W-1:0] pick_distance();
    case ($urandom_range(11, 0))
      0:       return DIST_W'($urandom_range(DIST_TOP, 0));
      1:       return DIST_W'($urandom_range(DIST_TOP, DIST_LIMIT + 1));
      2:       return clear_r;
      3:       return DIST_W'($urandom_range(clear_r, 0));
      default: return palette[$urandom_range(palette_n - 1, 0)];
    endcase
  endfunction

  task automatic refresh_palette();
    int unsigned span;
    span      = (clear_r < DIST_LIMIT) ? DIST_LIMIT - clear_r : 0;
    palette_n = $urandom_range(4, 1);
    foreach (palette[i])
      palette[i] = (span != 0) ? DIST_W'(clear_r + $urandom_range(span, 1)) : DIST_W'(DIST_LIMIT);
  endtask

  task automatic send_reading(input logic [SLOT_W-1:0] slot, input logic [DIST_W-1:0] dist_mm);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    slot_i        <= slot;
    distance_mm_i <= dist_mm;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    // Beat taken: store the saturated reading, then predict.
    if (slot < NUM_SLOTS) map_mm[slot] = (dist_mm > DIST_LIMIT) ? DIST_W'(DIST_LIMIT) : dist_mm;
    heading_q.push_back(predict_heading());
    readings_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (heading_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_SWEEP_LOW:  sweep_lo_r = data[SLOT_W-1:0];
      REG_SWEEP_HIGH: sweep_hi_r = data[SLOT_W-1:0];
      REG_MIN_CLEAR:  clear_r    = data[DIST_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic [SLOT_W-1:0] lo, input logic [SLOT_W-1:0] hi,
                              input logic [DIST_W-1:0] clear);
    wait_drained();
    write_reg(REG_SWEEP_LOW, CFG_DATA_W'(lo));
    write_reg(REG_SWEEP_HIGH, CFG_DATA_W'(hi));
    write_reg(REG_MIN_CLEAR, CFG_DATA_W'(clear));
    cfg_we_i <= 1'b0;
    settings_applied++;
  endtask

  task automatic run_random_phase(input logic [SLOT_W-1:0] lo, input logic [SLOT_W-1:0] hi,
                                  input logic [DIST_W-1:0] clear, input int unsigned count);
    apply_config(lo, hi, clear);
    refresh_palette();
    repeat (count) send_reading(pick_slot(), pick_distance());
  endtask

  task automatic test_reset_defaults();
    // Map is all zero after reset: front blocked, then at and just above clearance.
    send_reading(SLOT_W'(FRONT_SLOT), '0);
    send_reading(SLOT_W'(FRONT_SLOT), MIN_CLEAR_RST);
    send_reading(SLOT_W'(FRONT_SLOT), DIST_W'(MIN_CLEAR_RST + 1));
  endtask

  task automatic test_directed_cases();
    send_reading(5'd0, DIST_TOP);
    send_reading(5'd1, DIST_W'(DIST_LIMIT));
    send_reading(5'd18, DIST_W'(DIST_LIMIT));
    send_reading(5'd17, DIST_W'(DIST_LIMIT));
    send_reading(5'd0, 14'd50);
    send_reading(5'd1, '0);
    // Out-of-map slots store nothing.
    send_reading(5'd31, 14'd5000);
    send_reading(5'd19, '0);
    send_reading(5'd5, DIST_W'(DIST_LIMIT + 1));
    send_reading(5'd5, '0);
    send_reading(SLOT_W'(FRONT_SLOT), '0);
    send_reading(SLOT_W'(FRONT_SLOT), 14'd200);
  endtask

  task automatic test_register_sweep();
    // Best at slot 1 with an equal slot 0 that must not widen the opening.
    apply_config(5'd1, 5'd18, MIN_CLEAR_RST);
    send_reading(5'd17, '0);
    send_reading(5'd1, DIST_W'(DIST_LIMIT));
    send_reading(5'd0, DIST_W'(DIST_LIMIT));
    apply_config(5'd18, 5'd0, MIN_CLEAR_RST);
    send_reading(5'd2, 14'd3000);
    apply_config(5'd0, 5'd31, MIN_CLEAR_RST);
    send_reading(5'd3, 14'd3000);
    apply_config(5'd31, 5'd31, '0);
    send_reading(5'd4, 14'd1);
    apply_config(5'd0, 5'd18, '0);
    send_reading(SLOT_W'(FRONT_SLOT), 14'd1);
    apply_config(5'd0, 5'd18, DIST_W'(DIST_LIMIT));
    send_reading(SLOT_W'(FRONT_SLOT), DIST_TOP);
    // An unmapped index must leave every register alone.
    wait_drained();
    write_reg(REG_UNMAPPED, '1);
    cfg_we_i <= 1'b0;
    send_reading(5'd6, 14'd9000);
  endtask

  task automatic test_random_sender_idle();
    send_idle_pct  = 8;
    recv_stall_pct = 86;
    run_random_phase(SWEEP_LOW_RST, SWEEP_HIGH_RST, MIN_CLEAR_RST, 300);
    run_random_phase(5'd5, 5'd12, DIST_W'($urandom_range(6000, 0)), 200);
    run_random_phase(5'd0, 5'd31, '0, 150);
  endtask

  task automatic test_random_receiver_idle();
    send_idle_pct  = 86;
    recv_stall_pct = 8;
    run_random_phase(5'd9, 5'd9, DIST_W'($urandom_range(9999, 0)), 200);
    run_random_phase(5'd18, 5'd0, MIN_CLEAR_RST, 60);
    run_random_phase(5'd31, 5'd31, MIN_CLEAR_RST, 40);
    run_random_phase(5'd0, 5'd18, DIST_W'(DIST_LIMIT - 1), 150);
  endtask

  task automatic test_random_no_idle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random_phase(SWEEP_LOW_RST, SWEEP_HIGH_RST, MIN_CLEAR_RST, 400);
    run_random_phase(SLOT_W'($urandom_range(8, 0)), SLOT_W'($urandom_range(31, 9)),
                     DIST_W'($urandom_range(9999, 0)), 300);
    run_random_phase(5'd0, 5'd18, DIST_W'(DIST_LIMIT), 60);
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 30;
    apply_config(SWEEP_LOW_RST, SWEEP_HIGH_RST, MIN_CLEAR_RST);
    refresh_palette();
    // Hold the output while the sender keeps offering beats.
    hold_toggle <= ~hold_toggle;
    repeat (30) send_reading(pick_slot(), pick_distance());
  endtask

  task automatic test_drain_pause();
    send_idle_pct  = 20;
    recv_stall_pct = 50;
    repeat (15) send_reading(pick_slot(), pick_distance());
    wait_drained();
    repeat (15) send_reading(pick_slot(), pick_distance());
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_directed_cases();
    test_register_sweep();
    test_random_sender_idle();
    test_random_receiver_idle();
    test_random_no_idle();
    test_backpressure();
    test_drain_pause();

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Covered %0d readings, %0d headings checked, %0d register settings,",
             readings_sent, headings_checked, settings_applied);
    $display("with sender gaps, receiver stalls, a long output hold-off and a full drain.");
    if (mismatch_count == 0 && heading_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d headings never seen", mismatch_count, heading_q.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
